// ----- rtl/core/ascii_frame_receiver_unit_defines.svh -----
// ----------------------------------------------------------------------------
// ASCII frame receiver assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASCII_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define ASCII_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define AFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/afr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII frame receiver package
// Widths, codes, reset values and shared structs.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int DEF_BUFFER_DEPTH = 128;

    localparam int TIMEOUT_W  = 24;
    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 2;
    localparam int EVENT_W    = 3;
    localparam int POS_W      = 7;
    localparam int ELAPSED_W  = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [TIMEOUT_W-1:0] DEF_TIMEOUT_US = 24'd1400000;
    localparam logic [CHAR_W-1:0]    DEF_START_CHAR = 8'd123;
    localparam logic [CHAR_W-1:0]    DEF_END_CHAR   = 8'd125;
    localparam logic [CHAR_W-1:0]    ASCII_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0]    LEN_RADIX      = 8'd10;
    localparam int                   FRAME_OVERHEAD = 5;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = '1;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // result events
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_STORED  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_GOOD    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LEN_ERR = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 2'd2;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_limit_us;
        logic [CHAR_W-1:0]    start_char;
        logic [CHAR_W-1:0]    end_char;
    } cfg_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [CHAR_W-1:0]  echo_byte;
        logic [POS_W-1:0]   position;
        logic [CHAR_W-1:0]  operation;
        logic [CHAR_W-1:0]  payload_length;
    } result_t;

    typedef struct packed {
        logic in_frame;
        logic frame_ready;
    } status_t;

endpackage

// ----- rtl/core/afr_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII frame receiver configuration registers
// Timeout limit and frame delimiter characters, written by index.
// ----------------------------------------------------------------------------
module afr_cfg_regs
    import afr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_TIMEOUT:    cfg_next.timeout_limit_us = wr_data[TIMEOUT_W-1:0];
                REG_START_CHAR: cfg_next.start_char       = wr_data[CHAR_W-1:0];
                REG_END_CHAR:   cfg_next.end_char         = wr_data[CHAR_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit_us <= DEF_TIMEOUT_US;
            cfg_reg.start_char       <= DEF_START_CHAR;
            cfg_reg.end_char         <= DEF_END_CHAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/afr_frame_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII frame receiver frame control
// Frame state, write position, header digits and elapsed-time counter.
// Computes one result per item and updates state when the item retires.
// ----------------------------------------------------------------------------
module afr_frame_ctrl
    import afr_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [KIND_W-1:0] kind,
    input  logic [CHAR_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output result_t           res,
    output status_t           status
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int NW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = PW + 2;
    localparam int CW = (NW > CHAR_W) ? NW : CHAR_W;

    logic                 in_frame_reg,    in_frame_next;
    logic                 frame_ready_reg, frame_ready_next;
    logic                 timer_rearm_reg, timer_rearm_next;
    logic [PW-1:0]        wr_pos_reg,      wr_pos_next;
    logic                 start_found_reg, start_found_next;
    logic [PW-1:0]        start_pos_reg,   start_pos_next;
    logic [CHAR_W-1:0]    op_digit_reg,    op_digit_next;
    logic [CHAR_W-1:0]    tens_digit_reg,  tens_digit_next;
    logic [CHAR_W-1:0]    ones_digit_reg,  ones_digit_next;
    logic [ELAPSED_W-1:0] elapsed_reg,     elapsed_next;

    logic                 is_start;
    logic                 is_end;
    logic [SW-1:0]        pos_x;
    logic [SW-1:0]        sp_x;
    logic [NW-1:0]        next_raw;
    logic                 wrap;
    logic [NW-1:0]        next_eff;
    logic [CHAR_W-1:0]    tens_d;
    logic [CHAR_W-1:0]    ones_d;
    logic [CHAR_W-1:0]    len_v;
    logic [CHAR_W-1:0]    op_v;
    logic                 len_match;
    logic                 timed_out;
    result_t              res_c;

    assign is_start = (rx_byte == cfg.start_char);
    assign is_end   = (rx_byte == cfg.end_char);
    assign pos_x    = SW'(wr_pos_reg);
    assign sp_x     = SW'(start_pos_reg);
    assign next_raw = NW'(wr_pos_reg) + NW'(1);
    assign wrap     = (next_raw >= NW'(BUFFER_DEPTH));
    assign next_eff = wrap ? '0 : next_raw;

    // digits as they stand after this byte is stored
    assign tens_d    = tens_digit_next - ASCII_ZERO;
    assign ones_d    = ones_digit_next - ASCII_ZERO;
    assign len_v     = CHAR_W'(tens_d * LEN_RADIX) + ones_d;
    assign op_v      = op_digit_next - ASCII_ZERO;
    assign len_match = (next_eff >= NW'(FRAME_OVERHEAD))
                       && (CW'(len_v) == CW'(next_eff - NW'(FRAME_OVERHEAD)));
    // a rearming byte restarts the count at zero, which never exceeds the limit
    assign timed_out = !timer_rearm_reg
                       && (elapsed_reg > ELAPSED_W'(cfg.timeout_limit_us));

    // header capture and position advance
    always_comb
    begin
        start_found_next = start_found_reg;
        start_pos_next   = start_pos_reg;
        op_digit_next    = op_digit_reg;
        tens_digit_next  = tens_digit_reg;
        ones_digit_next  = ones_digit_reg;
        if (start_found_reg)
        begin
            if (pos_x == sp_x + SW'(1))
                op_digit_next = rx_byte;
            else if (pos_x == sp_x + SW'(2))
                tens_digit_next = rx_byte;
            else if (pos_x == sp_x + SW'(3))
                ones_digit_next = rx_byte;
        end
        else if (is_start)
        begin
            start_found_next = 1'b1;
            start_pos_next   = wr_pos_reg;
            op_digit_next    = '0;
            tens_digit_next  = '0;
            ones_digit_next  = '0;
        end
        // wrap forgets the frame start
        if (wrap)
            start_found_next = 1'b0;
    end

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        frame_ready_next = frame_ready_reg;
        timer_rearm_next = timer_rearm_reg;
        wr_pos_next      = wr_pos_reg;
        elapsed_next     = elapsed_reg;
        res_c            = '0;
        case (kind)
            KIND_TICK:
            begin
                if (elapsed_reg != ELAPSED_MAX)
                    elapsed_next = elapsed_reg + ELAPSED_W'(1);
            end
            KIND_RELEASE:
            begin
                frame_ready_next = 1'b0;
            end
            KIND_BYTE:
            begin
                if (is_start)
                    in_frame_next = 1'b1;
                if ((in_frame_reg || is_start) && !frame_ready_reg)
                begin
                    timer_rearm_next = 1'b0;
                    if (timer_rearm_reg)
                        elapsed_next = '0;
                    wr_pos_next = next_eff[PW-1:0];
                    res_c.echo_byte = rx_byte;
                    res_c.position  = POS_W'(wr_pos_reg);
                    if (is_end && start_found_next && len_match)
                    begin
                        // good frame wins over timeout
                        timer_rearm_next     = 1'b1;
                        in_frame_next        = 1'b0;
                        frame_ready_next     = 1'b1;
                        wr_pos_next          = '0;
                        res_c.event_res      = EV_GOOD;
                        res_c.operation      = op_v;
                        res_c.payload_length = len_v;
                    end
                    else if (timed_out)
                    begin
                        in_frame_next    = 1'b0;
                        timer_rearm_next = 1'b1;
                        wr_pos_next      = '0;
                        res_c            = '0;
                        res_c.event_res  = EV_TIMEOUT;
                    end
                    else if (is_end)
                    begin
                        wr_pos_next          = '0;
                        res_c.event_res      = EV_LEN_ERR;
                        res_c.payload_length = start_found_next ? len_v : '0;
                    end
                    else
                    begin
                        res_c.event_res = EV_STORED;
                    end
                end
            end
            default:
            begin
                res_c = '0;
            end
        endcase
    end

    // any stored byte that ends the frame or restarts the buffer clears the start
    logic restart;
    logic stored;

    assign stored  = (kind == KIND_BYTE) && (in_frame_reg || is_start) && !frame_ready_reg;
    assign restart = (res_c.event_res == EV_GOOD) || (res_c.event_res == EV_TIMEOUT)
                     || (res_c.event_res == EV_LEN_ERR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            frame_ready_reg <= 1'b0;
            timer_rearm_reg <= 1'b1;
            wr_pos_reg      <= '0;
            start_found_reg <= 1'b0;
            start_pos_reg   <= '0;
            op_digit_reg    <= '0;
            tens_digit_reg  <= '0;
            ones_digit_reg  <= '0;
            elapsed_reg     <= '0;
        end
        else if (step)
        begin
            in_frame_reg    <= in_frame_next;
            frame_ready_reg <= frame_ready_next;
            timer_rearm_reg <= timer_rearm_next;
            wr_pos_reg      <= wr_pos_next;
            elapsed_reg     <= elapsed_next;
            if (stored)
            begin
                start_found_reg <= restart ? 1'b0 : start_found_next;
                start_pos_reg   <= start_pos_next;
                op_digit_reg    <= op_digit_next;
                tens_digit_reg  <= tens_digit_next;
                ones_digit_reg  <= ones_digit_next;
            end
        end
    end

    assign res                = res_c;
    assign status.in_frame    = in_frame_reg;
    assign status.frame_ready = frame_ready_reg;

endmodule

// ----- rtl/core/ascii_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII frame receiver unit
// Parses framed UART bytes ({ op len len payload }) with a frame timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, kind, rx_byte) takes a received byte,
//   a one-microsecond tick or a release of a completed frame. Every input
//   transaction yields exactly one result transaction on the output channel
//   (out_valid/out_ready, event_res, echo_byte, position, operation,
//   payload_length), in order.
//   An input transaction passes through the input register, then through the
//   frame logic into the result register, which drives out_valid.
//   Throughput is one item per cycle while out_ready stays high; the frame
//   state update is a single pass of the frame control logic between those
//   two registers. When the receiver stalls, the result register holds and
//   the input register fills; in_ready drops only when both are occupied.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; the user must write it only while the unit is idle (not enforced).
//   Reset clears both pipeline valid flags, closes any frame, restores the
//   default timeout (1400000 us) and delimiters ('{', '}').
// ----------------------------------------------------------------------------
`include "ascii_frame_receiver_unit_defines.svh"

module ascii_frame_receiver_unit
    import afr_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [CHAR_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [EVENT_W-1:0]    event_res,
    output logic [CHAR_W-1:0]     echo_byte,
    output logic [POS_W-1:0]      position,
    output logic [CHAR_W-1:0]     operation,
    output logic [CHAR_W-1:0]     payload_length,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              in_v_reg,  in_v_next;
    logic [KIND_W-1:0] kind_reg;
    logic [CHAR_W-1:0] byte_reg;
    logic              out_v_reg, out_v_next;
    result_t           res_reg;
    logic              advance;
    logic              in_take;
    cfg_t              cfg;
    result_t           fc_res;
    status_t           fc_status;

    assign cfg_ready = 1'b1;
    assign advance   = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready  = !in_v_reg || advance;
    assign in_take   = in_valid && in_ready;

    afr_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    afr_frame_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_frame_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .kind    (kind_reg),
        .rx_byte (byte_reg),
        .cfg     (cfg),
        .res     (fc_res),
        .status  (fc_status)
    );

    always_comb
    begin
        if (in_take)
            in_v_next = 1'b1;
        else if (advance)
            in_v_next = 1'b0;
        else
            in_v_next = in_v_reg;

        if (advance)
            out_v_next = 1'b1;
        else if (out_ready)
            out_v_next = 1'b0;
        else
            out_v_next = out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            byte_reg <= rx_byte;
        end
        if (advance)
            res_reg <= fc_res;
    end

    assign out_valid      = out_v_reg;
    assign event_res      = res_reg.event_res;
    assign echo_byte      = res_reg.echo_byte;
    assign position       = res_reg.position;
    assign operation      = res_reg.operation;
    assign payload_length = res_reg.payload_length;

    `AFR_ASSERT_NEXT(a_in_item_held, clk, rst_n, in_v_reg && !advance, in_v_reg, "input item dropped before retiring")
    `AFR_ASSERT_NEXT(a_good_sets_ready, clk, rst_n, advance && (fc_res.event_res == EV_GOOD), fc_status.frame_ready, "good frame did not mark frame ready")
    `AFR_ASSERT_IMPLIES(a_timeout_clean, clk, rst_n, out_valid && (event_res == EV_TIMEOUT), (echo_byte == '0) && (position == '0) && (operation == '0) && (payload_length == '0), "timeout result carries payload")

endmodule
